@@ hw/rtl/stack_machine_execute_unit_defines.svh @@
// Assertion helpers used by the execute unit RTL.
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SMX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SMX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/smx_pkg.sv @@
package smx_pkg;

    localparam int DATA_W      = 32;
    localparam int PC_OUT_W    = 12;
    localparam int DEPTH_OUT_W = 9;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 64;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,  OP_POP   = 5'd1,  OP_SWAP  = 5'd2,  OP_DUP   = 5'd3,
        OP_OVER  = 5'd4,  OP_SIZE  = 5'd5,  OP_INC   = 5'd6,  OP_ADD   = 5'd7,
        OP_SUB   = 5'd8,  OP_MUL   = 5'd9,  OP_DIV   = 5'd10, OP_MOD   = 5'd11,
        OP_NOT   = 5'd12, OP_AND   = 5'd13, OP_OR    = 5'd14, OP_XOR   = 5'd15,
        OP_SHL   = 5'd16, OP_SHR   = 5'd17, OP_LDI   = 5'd18, OP_LDS   = 5'd19,
        OP_STI   = 5'd20, OP_STS   = 5'd21, OP_CMP   = 5'd22, OP_NEG   = 5'd23,
        OP_JMP   = 5'd24, OP_JNZ   = 5'd25, OP_PRINT = 5'd26, OP_NOP   = 5'd27,
        OP_HALT  = 5'd28
    } op_t;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_SHL, ALU_SHR,
        ALU_CMP, ALU_INC, ALU_NOT, ALU_SGN, ALU_MUL, ALU_DIV, ALU_MOD
    } alu_op_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_DIV0  = 3'd1,
        ERR_UNDER = 3'd2,
        ERR_OVER  = 3'd3,
        ERR_ADDR  = 3'd4
    } err_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_A, ST_RD_B, ST_CHECK, ST_ALU,
        ST_WB, ST_WB2, ST_RD_TOP, ST_TOP, ST_OUT
    } state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

    // entries an opcode needs on the stack
    function automatic logic [1:0] need_of(op_t op);
        case (op)
            OP_POP, OP_STI, OP_JNZ, OP_DUP, OP_INC, OP_NOT, OP_LDS, OP_NEG: need_of = 2'd1;
            OP_SWAP, OP_OVER, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND,
            OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_CMP, OP_STS:                    need_of = 2'd2;
            default:                                                          need_of = 2'd0;
        endcase
    endfunction

    // stack pointer change, two's complement
    function automatic logic [1:0] grow_of(op_t op);
        case (op)
            OP_PUSH, OP_SIZE, OP_LDI, OP_DUP, OP_OVER:                        grow_of = 2'b01;
            OP_POP, OP_STI, OP_JNZ, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_CMP:                    grow_of = 2'b11;
            OP_STS:                                                           grow_of = 2'b10;
            default:                                                          grow_of = 2'b00;
        endcase
    endfunction

    function automatic logic is_alu(op_t op);
        case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
            OP_SHL, OP_SHR, OP_CMP, OP_INC, OP_NOT, OP_NEG: is_alu = 1'b1;
            default:                                        is_alu = 1'b0;
        endcase
    endfunction

    function automatic alu_op_t alu_op_of(op_t op);
        case (op)
            OP_SUB:  alu_op_of = ALU_SUB;
            OP_MUL:  alu_op_of = ALU_MUL;
            OP_DIV:  alu_op_of = ALU_DIV;
            OP_MOD:  alu_op_of = ALU_MOD;
            OP_AND:  alu_op_of = ALU_AND;
            OP_OR:   alu_op_of = ALU_OR;
            OP_XOR:  alu_op_of = ALU_XOR;
            OP_SHL:  alu_op_of = ALU_SHL;
            OP_SHR:  alu_op_of = ALU_SHR;
            OP_CMP:  alu_op_of = ALU_CMP;
            OP_INC:  alu_op_of = ALU_INC;
            OP_NOT:  alu_op_of = ALU_NOT;
            OP_NEG:  alu_op_of = ALU_SGN;
            default: alu_op_of = ALU_ADD;
        endcase
    endfunction

endpackage

@@ hw/rtl/smx_alu.sv @@
module smx_alu import smx_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output alu_rsp_t          rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    alu_op_t           op_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W:0]   acc_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic [DATA_W-1:0] res_reg;

    logic [DATA_W-1:0] simple_res;
    logic [DATA_W-1:0] a_abs;
    logic [DATA_W-1:0] b_abs;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;
    logic              rem_ge;
    logic              shift_big;

    assign a_abs     = a[DATA_W-1] ? (~a + 1'b1) : a;
    assign b_abs     = b[DATA_W-1] ? (~b + 1'b1) : b;
    assign shift_big = |a[DATA_W-1:5];

    // restoring divide step: quotient bits shift into x_reg
    assign rem_sh  = {acc_reg[DATA_W-1:0], x_reg[DATA_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, y_reg};
    assign rem_sub = rem_sh - {1'b0, y_reg};

    always_comb begin
        case (req.op)
            ALU_ADD: simple_res = b + a;
            ALU_SUB: simple_res = b - a;
            ALU_AND: simple_res = b & a;
            ALU_OR:  simple_res = b | a;
            ALU_XOR: simple_res = b ^ a;
            ALU_SHL: simple_res = shift_big ? '0 : (b << a[4:0]);
            ALU_SHR: simple_res = shift_big ? '0 : (b >> a[4:0]);
            ALU_CMP: simple_res = (a == b) ? '1 : '0;
            ALU_INC: simple_res = a + 1'b1;
            ALU_NOT: simple_res = ~a;
            ALU_SGN: simple_res = {DATA_W{a[DATA_W-1]}};
            default: simple_res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                op_reg <= req.op;
                case (req.op)
                    ALU_MUL: begin
                        x_reg    <= b;
                        y_reg    <= a;
                        acc_reg  <= '0;
                        cnt_reg  <= 6'd32;
                        busy_reg <= 1'b1;
                    end
                    ALU_DIV, ALU_MOD: begin
                        x_reg     <= b_abs;
                        y_reg     <= a_abs;
                        acc_reg   <= '0;
                        cnt_reg   <= 6'd32;
                        neg_q_reg <= a[DATA_W-1] ^ b[DATA_W-1];
                        neg_r_reg <= b[DATA_W-1];
                        busy_reg  <= 1'b1;
                    end
                    default: begin
                        res_reg  <= simple_res;
                        done_reg <= 1'b1;
                    end
                endcase
            end else if (busy_reg) begin
                if (cnt_reg != 6'd0) begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (op_reg == ALU_MUL) begin
                        if (y_reg[0]) begin
                            acc_reg <= acc_reg + {1'b0, x_reg};
                        end
                        x_reg <= x_reg << 1;
                        y_reg <= y_reg >> 1;
                    end else begin
                        acc_reg <= rem_ge ? rem_sub : rem_sh;
                        x_reg   <= {x_reg[DATA_W-2:0], rem_ge};
                    end
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    case (op_reg)
                        ALU_MUL: res_reg <= acc_reg[DATA_W-1:0];
                        ALU_DIV: res_reg <= neg_q_reg ? (~x_reg + 1'b1) : x_reg;
                        default: res_reg <= neg_r_reg ? (~acc_reg[DATA_W-1:0] + 1'b1)
                                                      : acc_reg[DATA_W-1:0];
                    endcase
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

@@ hw/rtl/stack_machine_execute_unit.sv @@
// Stack machine execute unit: one instruction per input transfer, one status
// word per result transfer. After reset the data memory is cleared, one word a
// cycle, so no instruction is taken until the clear is done. An instruction then
// goes from acceptance to result through two operand reads, a write-back and a
// read of the new top, in that order, set by the single read port of the operand
// stack memory. Swap adds a second write-back; the simple ALU instructions (inc,
// add, sub, not, and, or, xor, shifts, cmp, neg) add an ALU step. Multiply, divide
// and modulo iterate in the shared ALU. Once halted, the result follows acceptance
// after only the read of the top. A new item is taken no earlier than the cycle
// after the previous result transfer.
`include "stack_machine_execute_unit_defines.svh"

module stack_machine_execute_unit import smx_pkg::*; #(
    parameter int STACK_DEPTH = 256,
    parameter int MEM_DEPTH   = 1024,
    parameter int PROG_DEPTH  = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [4:0] action, [36:5] immediate
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [11:0] next_pc, [43:12] top_value, [52:44] stack_depth, [53] print_valid,
    // [54] print_empty, [55] halted, [58:56] error_code
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int MW = $clog2(MEM_DEPTH);
    localparam int CW = $clog2(PROG_DEPTH);

    state_t state_reg, state_next;
    logic [PW-1:0]        sp_reg, sp_next;
    logic [CW-1:0]        pc_reg, pc_next;
    logic                 halt_reg, halt_next;
    err_t                 err_reg, err_next;
    op_t                  op_reg, op_next;
    logic [DATA_W-1:0]    imm_reg, imm_next;
    logic [DATA_W-1:0]    a_reg, a_next;
    logic [DATA_W-1:0]    b_reg, b_next;
    logic [MW-1:0]        clr_reg, clr_next;
    logic                 pv_reg, pv_next;
    logic                 pe_reg, pe_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;

    logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
    logic [DATA_W-1:0] stk_rdata_reg;
    logic [DATA_W-1:0] dmem [MEM_DEPTH];
    logic [DATA_W-1:0] dm_rdata_reg;

    logic              stk_we;
    logic [SW-1:0]     stk_waddr, stk_raddr;
    logic [DATA_W-1:0] stk_wdata;
    logic              dm_we, dm_re;
    logic [MW-1:0]     dm_addr;
    logic [DATA_W-1:0] dm_wdata;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [1:0]    need;
    logic [1:0]    grow;
    err_t          err_now;
    logic          imm_mem_ok, a_mem_ok, imm_tgt_ok;
    logic [PW-1:0] sp_m1, sp_m2;
    logic [CW:0]   pc_s1, pc_s2;
    logic [CW-1:0] pc_p1, pc_p2;
    logic [DATA_W-1:0] top_val;

    assign need  = need_of(op_reg);
    assign grow  = grow_of(op_reg);
    assign sp_m1 = sp_reg - PW'(1);
    assign sp_m2 = sp_reg - PW'(2);

    assign imm_mem_ok = !imm_reg[DATA_W-1] && (imm_reg < DATA_W'(MEM_DEPTH));
    assign a_mem_ok   = !a_reg[DATA_W-1] && (a_reg < DATA_W'(MEM_DEPTH));
    assign imm_tgt_ok = !imm_reg[DATA_W-1] && (imm_reg < DATA_W'(PROG_DEPTH));

    // pc steps wrap modulo the program depth
    assign pc_s1 = {1'b0, pc_reg} + (CW+1)'(1);
    assign pc_s2 = {1'b0, pc_reg} + (CW+1)'(2);
    assign pc_p1 = (pc_s1 >= (CW+1)'(PROG_DEPTH)) ? CW'(pc_s1 - (CW+1)'(PROG_DEPTH))
                                                 : pc_s1[CW-1:0];
    assign pc_p2 = (pc_s2 >= (CW+1)'(PROG_DEPTH)) ? CW'(pc_s2 - (CW+1)'(PROG_DEPTH))
                                                 : pc_s2[CW-1:0];

    always_comb begin
        if (sp_reg < PW'(need)) begin
            err_now = ERR_UNDER;
        end else if (grow == 2'b01 && sp_reg >= PW'(STACK_DEPTH)) begin
            err_now = ERR_OVER;
        end else if ((op_reg == OP_DIV || op_reg == OP_MOD) && a_reg == '0) begin
            err_now = ERR_DIV0;
        end else if ((op_reg == OP_LDI || op_reg == OP_STI) && !imm_mem_ok) begin
            err_now = ERR_ADDR;
        end else if ((op_reg == OP_LDS || op_reg == OP_STS) && !a_mem_ok) begin
            err_now = ERR_ADDR;
        end else if ((op_reg == OP_JMP || (op_reg == OP_JNZ && a_reg != '0)) && !imm_tgt_ok) begin
            err_now = ERR_ADDR;
        end else begin
            err_now = ERR_NONE;
        end
    end

    assign top_val = (sp_reg == '0) ? '0 : stk_rdata_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == MW'(MEM_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = halt_reg ? ST_RD_TOP : ST_RD_A;
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_CHECK;
            ST_CHECK: begin
                if (err_now != ERR_NONE) begin
                    state_next = ST_RD_TOP;
                end else if (is_alu(op_reg)) begin
                    state_next = ST_ALU;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_ALU:    if (alu_rsp.done) state_next = ST_WB;
            ST_WB:     state_next = (op_reg == OP_SWAP) ? ST_WB2 : ST_RD_TOP;
            ST_WB2:    state_next = ST_RD_TOP;
            ST_RD_TOP: state_next = ST_TOP;
            ST_TOP:    state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        sp_next   = sp_reg;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        err_next  = err_reg;
        op_next   = op_reg;
        imm_next  = imm_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        clr_next  = clr_reg;
        pv_next   = pv_reg;
        pe_next   = pe_reg;
        out_next  = out_reg;
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SW-1:0];
        stk_wdata = imm_reg;
        stk_raddr = sp_m1[SW-1:0];
        dm_we     = 1'b0;
        dm_re     = 1'b0;
        dm_addr   = imm_reg[MW-1:0];
        dm_wdata  = a_reg;
        alu_req.start = 1'b0;
        alu_req.op    = alu_op_of(op_reg);

        case (state_reg)
            ST_CLEAR: begin
                dm_we    = 1'b1;
                dm_addr  = clr_reg;
                dm_wdata = '0;
                clr_next = clr_reg + MW'(1);
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next  = op_t'(s_tdata[4:0]);
                    imm_next = s_tdata[36:5];
                    pv_next  = 1'b0;
                    pe_next  = 1'b0;
                end
            end
            ST_RD_B: begin
                a_next    = stk_rdata_reg;
                stk_raddr = sp_m2[SW-1:0];
            end
            ST_CHECK: begin
                b_next  = stk_rdata_reg;
                dm_re   = 1'b1;
                dm_addr = (op_reg == OP_LDI) ? imm_reg[MW-1:0] : a_reg[MW-1:0];
                if (err_now != ERR_NONE) begin
                    halt_next = 1'b1;
                    err_next  = err_now;
                end else begin
                    alu_req.start = is_alu(op_reg);
                end
            end
            ST_WB: begin
                sp_next = sp_reg + {{(PW-2){grow[1]}}, grow};
                pc_next = pc_p1;
                case (op_reg)
                    OP_PUSH: begin
                        stk_we  = 1'b1;
                        pc_next = pc_p2;
                    end
                    OP_SIZE: begin
                        stk_we    = 1'b1;
                        stk_wdata = DATA_W'(sp_reg);
                    end
                    OP_DUP: begin
                        stk_we    = 1'b1;
                        stk_wdata = a_reg;
                    end
                    OP_OVER: begin
                        stk_we    = 1'b1;
                        stk_wdata = b_reg;
                    end
                    OP_LDI: begin
                        stk_we    = 1'b1;
                        stk_wdata = dm_rdata_reg;
                        pc_next   = pc_p2;
                    end
                    OP_LDS: begin
                        stk_we    = 1'b1;
                        stk_waddr = sp_m1[SW-1:0];
                        stk_wdata = dm_rdata_reg;
                    end
                    OP_INC, OP_NOT, OP_NEG: begin
                        stk_we    = 1'b1;
                        stk_waddr = sp_m1[SW-1:0];
                        stk_wdata = alu_rsp.result;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
                    OP_SHL, OP_SHR, OP_CMP: begin
                        stk_we    = 1'b1;
                        stk_waddr = sp_m2[SW-1:0];
                        stk_wdata = alu_rsp.result;
                    end
                    OP_SWAP: begin
                        stk_we    = 1'b1;
                        stk_waddr = sp_m2[SW-1:0];
                        stk_wdata = a_reg;
                    end
                    OP_STI: begin
                        dm_we   = 1'b1;
                        pc_next = pc_p2;
                    end
                    OP_STS: begin
                        dm_we    = 1'b1;
                        dm_addr  = a_reg[MW-1:0];
                        dm_wdata = b_reg;
                    end
                    OP_JMP:  pc_next = imm_reg[CW-1:0];
                    OP_JNZ:  pc_next = (a_reg != '0) ? imm_reg[CW-1:0] : pc_p2;
                    OP_PRINT: begin
                        pv_next = (sp_reg != '0);
                        pe_next = (sp_reg == '0);
                    end
                    OP_HALT: begin
                        halt_next = 1'b1;
                        pc_next   = pc_reg;
                    end
                    default: ;
                endcase
            end
            ST_WB2: begin
                stk_we    = 1'b1;
                stk_waddr = sp_m1[SW-1:0];
                stk_wdata = b_reg;
            end
            ST_TOP: begin
                out_next = {5'b0, err_reg, halt_reg, pe_reg, pv_reg,
                            DEPTH_OUT_W'(sp_reg), top_val, PC_OUT_W'(pc_reg)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            sp_reg    <= '0;
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            err_reg   <= err_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        imm_reg <= imm_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        pv_reg  <= pv_next;
        pe_reg  <= pe_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dmem[dm_addr] <= dm_wdata;
        end
        if (dm_re) begin
            dm_rdata_reg <= dmem[dm_addr];
        end
    end

    smx_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (a_reg),
        .b       (stk_rdata_reg),
        .rsp     (alu_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;

    `SMX_ASSERT_IMP(a_one_in_flight, aclk, aresetn, s_tready, !m_tvalid, "input taken while result pending")
    `SMX_ASSERT_NEXT(a_halt_sticks, aclk, aresetn, halt_reg, halt_reg, "halt flag cleared")
    `SMX_ASSERT_IMP(a_err_halts, aclk, aresetn, err_reg != ERR_NONE, halt_reg, "error without halt")
    `SMX_ASSERT_IMP(a_sp_range, aclk, aresetn, 1'b1, sp_reg <= PW'(STACK_DEPTH), "stack pointer past depth")

endmodule

@@ tb/stack_machine_execute_unit_checker.sv @@
module stack_machine_execute_unit_checker import smx_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   pending,
    output int                   checked,
    output int                   prints_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // highest field first, so next_pc sits in the low bits
    typedef struct packed {
        logic [2:0]  error_code;
        logic        halted;
        logic        print_empty;
        logic        print_valid;
        logic [8:0]  stack_depth;
        logic [31:0] top_value;
        logic [11:0] next_pc;
    } status_t;

    logic [31:0] stk [256];
    logic [31:0] dmem [1024];
    int          sp;
    logic [11:0] pc;
    logic        halted;
    logic [2:0]  err_latch;
    status_t     status_q[$];

    function automatic logic addr_ok(logic [31:0] v);
        return !v[31] && v < 32'd1024;
    endfunction

    function automatic logic target_ok(logic [31:0] v);
        return !v[31] && v < 32'd4096;
    endfunction

    task automatic execute_instruction(input logic [4:0] op, input logic [31:0] imm);
        int          need;
        int          grow;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [2:0]  e;
        logic [11:0] npc;
        logic        pv;
        logic        pe;
        status_t     st;
        need = 0; grow = 0; a = '0; b = '0; r = '0; e = ERR_NONE; pv = 0; pe = 0;
        if (!halted) begin
            case (op)
                OP_PUSH, OP_SIZE, OP_LDI: grow = 1;
                OP_POP, OP_STI, OP_JNZ: begin need = 1; grow = -1; end
                OP_SWAP: need = 2;
                OP_DUP: begin need = 1; grow = 1; end
                OP_OVER: begin need = 2; grow = 1; end
                OP_INC, OP_NOT, OP_LDS, OP_NEG: need = 1;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
                OP_SHL, OP_SHR, OP_CMP: begin need = 2; grow = -1; end
                OP_STS: begin need = 2; grow = -2; end
                default: ;
            endcase
            if (sp >= 1) a = stk[sp-1];
            if (sp >= 2) b = stk[sp-2];
            if (sp < need) e = ERR_UNDER;
            else if (grow > 0 && sp >= 256) e = ERR_OVER;
            else if ((op == OP_DIV || op == OP_MOD) && a == 0) e = ERR_DIV0;
            else if ((op == OP_LDI || op == OP_STI) && !addr_ok(imm)) e = ERR_ADDR;
            else if ((op == OP_LDS || op == OP_STS) && !addr_ok(a)) e = ERR_ADDR;
            else if ((op == OP_JMP || (op == OP_JNZ && a != 0)) && !target_ok(imm))
                e = ERR_ADDR;
            if (e != ERR_NONE) begin
                halted = 1;
                err_latch = e;
            end else begin
                npc = pc + 12'd1;
                case (op)
                    OP_PUSH: begin stk[sp] = imm; npc = pc + 12'd2; end
                    OP_SWAP: begin stk[sp-2] = a; stk[sp-1] = b; end
                    OP_DUP:  stk[sp] = a;
                    OP_OVER: stk[sp] = b;
                    OP_SIZE: stk[sp] = sp;
                    OP_INC:  stk[sp-1] = a + 1;
                    OP_ADD:  r = b + a;
                    OP_SUB:  r = b - a;
                    OP_MUL:  r = b * a;
                    OP_DIV: begin
                        if (b == 32'h8000_0000 && a == '1) r = b;
                        else r = $signed(b) / $signed(a);
                    end
                    OP_MOD: begin
                        if (b == 32'h8000_0000 && a == '1) r = '0;
                        else r = $signed(b) % $signed(a);
                    end
                    OP_NOT:  stk[sp-1] = ~a;
                    OP_AND:  r = b & a;
                    OP_OR:   r = b | a;
                    OP_XOR:  r = b ^ a;
                    OP_SHL:  r = (a >= 32) ? '0 : b << a[4:0];
                    OP_SHR:  r = (a >= 32) ? '0 : b >> a[4:0];
                    OP_LDI:  begin stk[sp] = dmem[imm[9:0]]; npc = pc + 12'd2; end
                    OP_LDS:  stk[sp-1] = dmem[a[9:0]];
                    OP_STI:  begin dmem[imm[9:0]] = a; npc = pc + 12'd2; end
                    OP_STS:  dmem[a[9:0]] = b;
                    OP_CMP:  r = (a == b) ? '1 : '0;
                    OP_NEG:  stk[sp-1] = a[31] ? '1 : '0;
                    OP_JMP:  npc = imm[11:0];
                    OP_JNZ:  npc = (a != 0) ? imm[11:0] : pc + 12'd2;
                    OP_PRINT: begin pv = sp >= 1; pe = sp < 1; end
                    OP_HALT: begin halted = 1; npc = pc; end
                    default: ;
                endcase
                if (need == 2 && grow == -1) stk[sp-2] = r;
                sp = sp + grow;
                pc = npc;
            end
        end
        st.next_pc     = pc;
        st.top_value   = (sp >= 1) ? stk[sp-1] : '0;
        st.stack_depth = sp[8:0];
        st.print_valid = pv;
        st.print_empty = pe;
        st.halted      = halted;
        st.error_code  = err_latch;
        status_q.push_back(st);
    endtask

    initial begin
        foreach (stk[i]) stk[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        sp = 0; pc = '0; halted = 0; err_latch = ERR_NONE;
        fail_count = 0; checked = 0; prints_seen = 0; pending = 0;
    end

    always @(posedge aclk) begin
        status_t want;
        status_t got;
        if (aresetn) begin
            // results drain before the next transfer is taken
            if (m_tvalid && m_tready) begin
                got = m_tdata[58:0];
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    checked++;
                    if (got.print_valid) prints_seen++;
                    if (got.next_pc !== want.next_pc) begin
                        $display("%0t: next_pc exp %h got %h", $time, want.next_pc,
                                 got.next_pc);
                        fail_count++;
                    end
                    if (got.top_value !== want.top_value) begin
                        $display("%0t: top_value exp %h got %h", $time, want.top_value,
                                 got.top_value);
                        fail_count++;
                    end
                    if (got.stack_depth !== want.stack_depth) begin
                        $display("%0t: stack_depth exp %0d got %0d", $time,
                                 want.stack_depth, got.stack_depth);
                        fail_count++;
                    end
                    if (got.print_valid !== want.print_valid ||
                        got.print_empty !== want.print_empty) begin
                        $display("%0t: print strobes exp %b%b got %b%b", $time,
                                 want.print_valid, want.print_empty,
                                 got.print_valid, got.print_empty);
                        fail_count++;
                    end
                    if (got.halted !== want.halted) begin
                        $display("%0t: halted exp %b got %b", $time, want.halted,
                                 got.halted);
                        fail_count++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $display("%0t: error_code exp %0d got %0d", $time,
                                 want.error_code, got.error_code);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                execute_instruction(s_tdata[4:0], s_tdata[36:5]);
        end
        pending = status_q.size();
    end

endmodule

@@ tb/stack_machine_execute_unit_test.sv @@
module stack_machine_execute_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import smx_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending;
    int                   checked;
    int                   prints_seen;

    int   sent;
    int   gen_sp;
    logic quiet;
    logic stim_done;
    int   stop_kind;

    stack_machine_execute_unit dut (.*);

    stack_machine_execute_unit_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // stack change per opcode, for keeping the generated program error free
    function automatic int sp_change(logic [4:0] op);
        case (op)
            OP_PUSH, OP_SIZE, OP_LDI, OP_DUP, OP_OVER: return 1;
            OP_POP, OP_STI, OP_JNZ, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_CMP: return -1;
            OP_STS: return -2;
            default: return 0;
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return '0;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [4:0] op, input logic [31:0] imm);
        if (!quiet && $urandom_range(0, 99) < 19) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata  = {3'b0, imm, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
        gen_sp += sp_change(op);
    endtask

    // make room or supply operands so that op cannot fault
    task automatic ensure(input int need, input int room);
        while (gen_sp < need) send(OP_PUSH, rand_word());
        while (gen_sp > 256 - room) send(OP_POP, '0);
    endtask

    task automatic random_instruction();
        logic [4:0] op;
        op = 5'($urandom_range(0, 31));
        case (op)
            OP_DIV, OP_MOD: begin
                ensure(1, 1);
                send(OP_PUSH, ($urandom_range(0, 3) == 0) ? '1 :
                              (($urandom >> $urandom_range(0, 31)) | 32'd1));
            end
            OP_SHL, OP_SHR: begin
                ensure(1, 1);
                send(OP_PUSH, $urandom_range(0, 40));
            end
            OP_LDS: begin
                ensure(0, 1);
                send(OP_PUSH, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 15));
            end
            OP_STS: begin
                ensure(1, 1);
                send(OP_PUSH, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 15));
            end
            OP_JNZ: begin
                ensure(0, 1);
                send(OP_PUSH, $urandom_range(0, 1) ? '0 : rand_word());
            end
            default: ensure((op == OP_SWAP || op == OP_OVER || sp_change(op) < 0) ? 2 :
                            (op == OP_PUSH || op == OP_SIZE || op == OP_LDI) ? 0 : 1,
                            sp_change(op) > 0 ? 1 : 0);
        endcase
        case (op)
            OP_LDI, OP_STI:
                send(op, $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 1023));
            OP_JMP, OP_JNZ: send(op, $urandom_range(0, 4095));
            OP_HALT: send(OP_NOP, $urandom);
            default: send(op, $urandom);
        endcase
    endtask

    // receiver: random stalls, one long hold-off, a quiet stretch
    initial begin
        logic held;
        held = 0;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && sent >= 1000) begin
                held = 1;
                m_tready = 0;
                repeat (300) @(negedge aclk);
            end
            m_tready = quiet || $urandom_range(0, 99) >= 19;
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle);
                $display("[stack_machine_execute_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 0; s_tvalid = 0; s_tdata = '0;
        sent = 0; gen_sp = 0; quiet = 0; stim_done = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1;

        // directed: empty print, extremes, division overflow, big shifts, memory ends
        send(OP_PRINT, '0);
        send(OP_PUSH, 32'h8000_0000);
        send(OP_PUSH, '1);
        send(OP_OVER, '0);
        send(OP_OVER, '0);
        send(OP_DIV, '0);
        send(OP_SWAP, '0);
        send(OP_MOD, '0);
        send(OP_PUSH, 32'h7fff_ffff);
        send(OP_INC, '0);
        send(OP_NEG, '0);
        send(OP_NOT, '0);
        send(OP_PUSH, 32);
        send(OP_SHL, '0);
        send(OP_SIZE, '0);
        send(OP_STI, 1023);
        send(OP_LDI, 1023);
        send(OP_DUP, '0);
        send(OP_CMP, '0);
        send(OP_PRINT, '0);
        send(OP_JNZ, 4095);
        send(5'd29, '1);
        send(5'd30, '0);
        send(5'd31, '0);
        send(OP_PUSH, 32'hffff_fff0);
        send(OP_PUSH, 0);
        send(OP_JNZ, 0);
        send(OP_JMP, 4095);

        while (sent < 1950) begin
            quiet = sent >= 1300 && sent < 1600;
            if (sent >= 500 && sent < 520) begin
                // fill the stack completely once
                while (gen_sp < 256) send(OP_PUSH, $urandom);
                send(OP_PRINT, '0);
                send(OP_POP, '0);
            end else
                random_instruction();
        end

        // the machine stops only once, so pick one way to stop it
        stop_kind = $urandom_range(0, 4);
        case (stop_kind)
            0: send(OP_HALT, '0);
            1: begin ensure(1, 1); send(OP_PUSH, '0); send(OP_DIV, '0); end
            2: begin while (gen_sp > 0) send(OP_POP, '0); send(OP_ADD, '0); end
            3: begin while (gen_sp < 256) send(OP_PUSH, $urandom); send(OP_DUP, '0); end
            default: begin
                ensure(0, 1);
                send(OP_PUSH, $urandom_range(0, 1) ? 32'd1024 : 32'h8000_0000);
                send(OP_LDS, '0);
            end
        endcase
        repeat (6) send(5'($urandom_range(0, 31)), $urandom);
        s_tvalid = 0;
        stim_done = 1;

        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("ran %0d instructions with stack fill, both print strobes, memory and jumps;",
                 sent);
        $display("checked %0d results (%0d prints), stop scenario %0d", checked,
                 prints_seen, stop_kind);
        if (fail_count == 0) begin
            $display("[stack_machine_execute_unit] OK");
        end else begin
            $display("[stack_machine_execute_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/smx_pkg.sv
hw/rtl/smx_alu.sv
hw/rtl/stack_machine_execute_unit.sv
tb/stack_machine_execute_unit_checker.sv
tb/stack_machine_execute_unit_test.sv
